/* src/dll_pkg.sv */
//------------------------------------------------------------------------------
// dll_pkg
// Shared types and codes for the doubly linked list engine.
//------------------------------------------------------------------------------
`default_nettype none

package dll_pkg;

    localparam logic [3:0] FN_PUSH_FRONT  = 4'd0;
    localparam logic [3:0] FN_PUSH_BACK   = 4'd1;
    localparam logic [3:0] FN_INS_AFTER   = 4'd2;
    localparam logic [3:0] FN_INS_BEFORE  = 4'd3;
    localparam logic [3:0] FN_POP_FRONT   = 4'd4;
    localparam logic [3:0] FN_POP_BACK    = 4'd5;
    localparam logic [3:0] FN_PEEK_FRONT  = 4'd6;
    localparam logic [3:0] FN_PEEK_BACK   = 4'd7;
    localparam logic [3:0] FN_REMOVE      = 4'd8;
    localparam logic [3:0] FN_FIND        = 4'd9;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT,
        OP_LOAD,
        OP_READ_HEAD,
        OP_READ_TAIL,
        OP_READ_CUR,
        OP_STEP,
        OP_FIRST_PUSH,
        OP_LINK_BEFORE,
        OP_LINK_AFTER,
        OP_FIX_PREV,
        OP_FIX_NEXT,
        OP_UNLINK,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] status;
        logic       use_data;
    } dp_cmd_t;

    typedef struct packed {
        logic init_done;
        logic match;
        logic searched_all;
        logic empty;
        logic full;
    } dp_stat_t;

endpackage

`default_nettype wire

/* src/dll_datapath.sv */
//------------------------------------------------------------------------------
// dll_datapath
// Node pool memories, list pointers and the search walker.
//------------------------------------------------------------------------------
`default_nettype none

module dll_datapath
    import dll_pkg::*;
#(
    parameter int NODES      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire dp_cmd_t     cmd,
    input  wire logic [3:0]  in_func,
    input  wire logic [31:0] in_key,
    input  wire logic [31:0] in_value,
    output dp_stat_t         stat,
    output logic [3:0]       func_q,
    output logic [1:0]       res_status,
    output logic [31:0]      res_data,
    output logic [6:0]       res_length,
    output logic             res_empty
);

    localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CW = $clog2(NODES + 1);

    logic [DATA_WIDTH-1:0] value_mem [NODES];
    logic [IW-1:0]         next_mem  [NODES];
    logic [IW-1:0]         prev_mem  [NODES];

    logic [IW-1:0] head_reg, tail_reg, free_reg, cur_reg, new_reg, init_reg;
    logic [CW-1:0] count_reg, steps_reg;
    logic [DATA_WIDTH-1:0] key_reg, val_reg;
    logic [DATA_WIDTH-1:0] rd_value_reg;
    logic [IW-1:0] rd_next_reg, rd_prev_reg;
    logic [IW-1:0] rd_free_next_reg;
    logic [3:0]    func_reg;
    logic          cur_end_reg;

    logic [1:0]  status_reg;
    logic [31:0] data_reg;

    assign func_q = func_reg;

    logic [31:0] widened;
    always_comb
    begin
        widened = 32'(signed'(rd_value_reg));
    end

    // Memory ports: one write of each array a cycle, registered reads.
    logic                  v_we, n_we, p_we;
    logic [IW-1:0]         v_wa, n_wa, p_wa;
    logic [IW-1:0]         n_wd, p_wd;

    always_comb
    begin
        v_we = 1'b0; v_wa = new_reg;
        n_we = 1'b0; n_wa = '0; n_wd = '0;
        p_we = 1'b0; p_wa = '0; p_wd = '0;
        case (cmd.op)
            OP_INIT:
            begin
                n_we = 1'b1; n_wa = init_reg;
                n_wd = (init_reg == IW'(NODES - 1)) ? '0 : init_reg + 1'b1;
                p_we = 1'b1; p_wa = init_reg; p_wd = '0;
            end
            OP_FIRST_PUSH:
            begin
                v_we = 1'b1;
            end
            OP_LINK_BEFORE:
            begin
                v_we = 1'b1;
                n_we = 1'b1; n_wa = new_reg; n_wd = cur_reg;
                p_we = 1'b1; p_wa = cur_reg; p_wd = new_reg;
            end
            OP_LINK_AFTER:
            begin
                v_we = 1'b1;
                n_we = 1'b1; n_wa = cur_reg; n_wd = new_reg;
                p_we = 1'b1; p_wa = new_reg; p_wd = cur_reg;
            end
            OP_FIX_PREV:
            begin
                // Finish insertion: new.prev = cur.prev and prev.next = new,
                // or new.next = cur.next and next.prev = new.
                if (func_reg == FN_PUSH_FRONT || func_reg == FN_INS_BEFORE)
                begin
                    p_we = 1'b1; p_wa = new_reg; p_wd = rd_prev_reg;
                    if (!cur_end_reg)
                    begin
                        n_we = 1'b1; n_wa = rd_prev_reg; n_wd = new_reg;
                    end
                end
                else
                begin
                    n_we = 1'b1; n_wa = new_reg; n_wd = rd_next_reg;
                    if (!cur_end_reg)
                    begin
                        p_we = 1'b1; p_wa = rd_next_reg; p_wd = new_reg;
                    end
                end
            end
            OP_UNLINK:
            begin
                n_we = 1'b1; n_wa = cur_reg; n_wd = free_reg;
                if (cur_reg != tail_reg)
                begin
                    p_we = 1'b1; p_wa = rd_next_reg; p_wd = rd_prev_reg;
                end
            end
            OP_FIX_NEXT:
            begin
                if (!cur_end_reg)
                begin
                    n_we = 1'b1; n_wa = rd_prev_reg; n_wd = rd_next_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    logic [IW-1:0] rd_addr;
    always_comb
    begin
        case (cmd.op)
            OP_READ_HEAD: rd_addr = head_reg;
            OP_READ_TAIL: rd_addr = tail_reg;
            OP_STEP:      rd_addr = rd_next_reg;
            default:      rd_addr = cur_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (v_we)
            value_mem[v_wa] <= val_reg;
        if (n_we)
            next_mem[n_wa] <= n_wd;
        if (p_we)
            prev_mem[p_wa] <= p_wd;
        rd_value_reg     <= value_mem[rd_addr];
        rd_next_reg      <= next_mem[rd_addr];
        rd_prev_reg      <= prev_mem[rd_addr];
        rd_free_next_reg <= next_mem[free_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            free_reg    <= '0;
            cur_reg     <= '0;
            new_reg     <= '0;
            init_reg    <= '0;
            count_reg   <= '0;
            steps_reg   <= '0;
            func_reg    <= '0;
            key_reg     <= '0;
            val_reg     <= '0;
            cur_end_reg <= 1'b0;
            status_reg  <= ST_OK;
            data_reg    <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_INIT:
                    init_reg <= init_reg + 1'b1;
                OP_LOAD:
                begin
                    func_reg  <= in_func;
                    key_reg   <= DATA_WIDTH'(in_key);
                    val_reg   <= DATA_WIDTH'(in_value);
                    steps_reg <= '0;
                    new_reg   <= free_reg;
                end
                OP_READ_HEAD:
                    cur_reg <= head_reg;
                OP_READ_TAIL:
                    cur_reg <= tail_reg;
                OP_STEP:
                begin
                    cur_reg   <= rd_next_reg;
                    steps_reg <= steps_reg + 1'b1;
                end
                OP_FIRST_PUSH:
                begin
                    head_reg  <= new_reg;
                    tail_reg  <= new_reg;
                    free_reg  <= rd_free_next_reg;
                    count_reg <= count_reg + 1'b1;
                end
                OP_LINK_BEFORE:
                begin
                    if (cur_reg == head_reg)
                        head_reg <= new_reg;
                    cur_end_reg <= (cur_reg == head_reg);
                    free_reg    <= rd_free_next_reg;
                    count_reg   <= count_reg + 1'b1;
                end
                OP_LINK_AFTER:
                begin
                    if (cur_reg == tail_reg)
                        tail_reg <= new_reg;
                    cur_end_reg <= (cur_reg == tail_reg);
                    free_reg    <= rd_free_next_reg;
                    count_reg   <= count_reg + 1'b1;
                end
                OP_UNLINK:
                begin
                    if (cur_reg == head_reg)
                        head_reg <= rd_next_reg;
                    if (cur_reg == tail_reg)
                        tail_reg <= rd_prev_reg;
                    cur_end_reg <= (cur_reg == head_reg);
                    free_reg    <= cur_reg;
                    count_reg   <= count_reg - 1'b1;
                end
                OP_RESULT:
                begin
                    status_reg <= cmd.status;
                    data_reg   <= cmd.use_data ? widened : '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign stat.init_done    = (init_reg == IW'(NODES - 1));
    assign stat.match        = (rd_value_reg == key_reg);
    assign stat.searched_all = (steps_reg + 1'b1 >= count_reg);
    assign stat.empty        = (count_reg == '0);
    assign stat.full         = (count_reg == CW'(NODES));

    assign res_status = status_reg;
    assign res_data   = data_reg;
    assign res_length = 7'(count_reg);
    assign res_empty  = (count_reg == '0);

endmodule

`default_nettype wire

/* src/dll_ctrl.sv */
//------------------------------------------------------------------------------
// dll_ctrl
// Sequencer for list operations and output handshake.
//------------------------------------------------------------------------------
`default_nettype none

module dll_ctrl
    import dll_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    input  wire logic [3:0] func_q,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_CHECK,
        S_WAIT_STEP,
        S_FOUND,
        S_FIX,
        S_FIX2,
        S_RESULT,
        S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] status_reg, status_next;
    logic       use_data_reg, use_data_next;
    logic       out_valid_reg, out_valid_next;
    dp_cmd_t    cmd_next;

    logic is_search, is_front;
    assign is_search = (func_q == FN_INS_AFTER) || (func_q == FN_INS_BEFORE)
                    || (func_q == FN_REMOVE) || (func_q == FN_FIND);
    assign is_front  = (func_q == FN_POP_FRONT) || (func_q == FN_PEEK_FRONT);

    always_comb
    begin
        state_next     = state_reg;
        status_next    = status_reg;
        use_data_next  = use_data_reg;
        out_valid_next = out_valid_reg;
        cmd_next       = '{op: OP_NONE, status: ST_OK, use_data: 1'b0};
        case (state_reg)
            S_INIT:
            begin
                cmd_next.op = OP_INIT;
                if (stat.init_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next.op   = OP_LOAD;
                    status_next   = ST_OK;
                    use_data_next = 1'b0;
                    state_next    = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_RESULT;
                case (func_q)
                    FN_PUSH_FRONT, FN_PUSH_BACK:
                    begin
                        if (stat.full)
                            status_next = ST_FULL;
                        else if (stat.empty)
                            cmd_next.op = OP_FIRST_PUSH;
                        else
                        begin
                            cmd_next.op = (func_q == FN_PUSH_FRONT) ?
                                          OP_READ_HEAD : OP_READ_TAIL;
                            state_next = S_FOUND;
                        end
                    end
                    FN_POP_FRONT, FN_POP_BACK, FN_PEEK_FRONT, FN_PEEK_BACK:
                    begin
                        if (stat.empty)
                            status_next = ST_EMPTY;
                        else
                        begin
                            cmd_next.op = is_front ? OP_READ_HEAD : OP_READ_TAIL;
                            use_data_next = 1'b1;
                            state_next = S_FOUND;
                        end
                    end
                    FN_INS_AFTER, FN_INS_BEFORE, FN_REMOVE, FN_FIND:
                    begin
                        if (stat.empty)
                            status_next = ST_NOTFOUND;
                        else
                        begin
                            cmd_next.op = OP_READ_HEAD;
                            state_next = S_CHECK;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_CHECK:
            begin
                if (stat.match)
                    state_next = S_FOUND;
                else if (stat.searched_all)
                begin
                    status_next = ST_NOTFOUND;
                    state_next  = S_RESULT;
                end
                else
                begin
                    cmd_next.op = OP_STEP;
                    state_next  = S_WAIT_STEP;
                end
            end
            S_WAIT_STEP:
            begin
                state_next = S_CHECK;
            end
            S_FOUND:
            begin
                state_next = S_RESULT;
                case (func_q)
                    FN_PUSH_FRONT, FN_INS_BEFORE:
                    begin
                        if (is_search && stat.full)
                            status_next = ST_FULL;
                        else
                        begin
                            cmd_next.op = OP_LINK_BEFORE;
                            state_next  = S_FIX;
                        end
                    end
                    FN_PUSH_BACK, FN_INS_AFTER:
                    begin
                        if (is_search && stat.full)
                            status_next = ST_FULL;
                        else
                        begin
                            cmd_next.op = OP_LINK_AFTER;
                            state_next  = S_FIX;
                        end
                    end
                    FN_POP_FRONT, FN_POP_BACK, FN_REMOVE:
                    begin
                        cmd_next.op = OP_UNLINK;
                        state_next  = S_FIX2;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_FIX:
            begin
                cmd_next.op = OP_FIX_PREV;
                state_next  = S_RESULT;
            end
            S_FIX2:
            begin
                cmd_next.op = OP_FIX_NEXT;
                state_next  = S_RESULT;
            end
            S_RESULT:
            begin
                cmd_next.op       = OP_RESULT;
                cmd_next.status   = status_reg;
                cmd_next.use_data = use_data_reg;
                out_valid_next    = 1'b1;
                state_next        = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            status_reg    <= ST_OK;
            use_data_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            status_reg    <= status_next;
            use_data_reg  <= use_data_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath commands are decoded in the same cycle so memory reads line up.
    assign cmd       = cmd_next;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* src/doubly_linked_list_engine_unit.sv */
//------------------------------------------------------------------------------
// doubly_linked_list_engine_unit
// Linked list of signed values in a node pool, driven one operation at a time.
//------------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         tdata = func[3:0], key[35:4], value[67:36], pad to 72
// m_axis    out        tdata = status[1:0], data_out[33:2], length[40:34],
//                              is_empty[41], pad to 48
//
// Push, pop and peek go straight to the head or tail; searching operations walk
// the list from the head through the pool's read port, a step and a check per node.
// After reset the free chain is written one entry a cycle, all NODES entries,
// before the first transaction is accepted. A stalled result holds the block.
`default_nettype none

module doubly_linked_list_engine_unit
    import dll_pkg::*;
#(
    parameter int NODES      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // func, key, value
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata   // status, data_out, length, is_empty
);

    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic [3:0]  func_q;
    logic [1:0]  res_status;
    logic [31:0] res_data;
    logic [6:0]  res_length;
    logic        res_empty;

    dll_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .func_q    (func_q),
        .stat      (stat),
        .cmd       (cmd)
    );

    dll_datapath #(
        .NODES      (NODES),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_func    (s_axis_tdata[3:0]),
        .in_key     (s_axis_tdata[35:4]),
        .in_value   (s_axis_tdata[67:36]),
        .stat       (stat),
        .func_q     (func_q),
        .res_status (res_status),
        .res_data   (res_data),
        .res_length (res_length),
        .res_empty  (res_empty)
    );

    assign m_axis_tdata = {6'd0, res_empty, res_length, res_data, res_status};

endmodule

`default_nettype wire

/* src/dll_checker.sv */
//------------------------------------------------------------------------------
// dll_checker
// Port-level checks of the list engine.
//------------------------------------------------------------------------------
`default_nettype none

module dll_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata
);

    a_len_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[41] == (m_axis_tdata[40:34] == 7'd0)))
        else $error("empty flag disagrees with length");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result pending");

    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[1:0] != 2'd0) |-> (m_axis_tdata[33:2] == 32'd0))
        else $error("data on failed status");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result dropped under stall");

endmodule

bind doubly_linked_list_engine_unit dll_checker u_dll_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

/* tb/sv/doubly_linked_list_engine_unit_test.sv */
//------------------------------------------------------------------------------
// doubly_linked_list_engine_unit_test
// Drives random and directed list operations into the engine, predicts each
// result with a behavioral list model and compares every output transaction.
//------------------------------------------------------------------------------
`default_nettype none

module doubly_linked_list_engine_unit_test;
    import dll_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] data;
        logic [6:0]  length;
        logic        empty;
    } list_result_t;

    class list_scoreboard;
        logic [31:0] contents[$];
        list_result_t pending[$];
        int errors;

        function int locate(logic [31:0] k);
            for (int i = 0; i < contents.size(); i++)
                if (contents[i] == k) return i;
            return -1;
        endfunction

        function void note_request(logic [3:0] fn, logic [31:0] k, logic [31:0] v);
            list_result_t r;
            int pos;
            r = '0;
            r.status = ST_OK;
            pos = locate(k);
            case (fn)
                FN_PUSH_FRONT, FN_PUSH_BACK:
                    if (contents.size() >= NODES) r.status = ST_FULL;
                    else if (fn == FN_PUSH_FRONT) contents.push_front(v);
                    else contents.push_back(v);
                FN_INS_AFTER, FN_INS_BEFORE:
                    if (pos < 0) r.status = ST_NOTFOUND;
                    else if (contents.size() >= NODES) r.status = ST_FULL;
                    else if (fn == FN_INS_AFTER) contents.insert(pos + 1, v);
                    else contents.insert(pos, v);
                FN_POP_FRONT, FN_POP_BACK, FN_PEEK_FRONT, FN_PEEK_BACK:
                    if (contents.size() == 0) r.status = ST_EMPTY;
                    else begin
                        case (fn)
                            FN_POP_FRONT: r.data = contents.pop_front();
                            FN_POP_BACK: r.data = contents.pop_back();
                            FN_PEEK_FRONT: r.data = contents[0];
                            default: r.data = contents[$];
                        endcase
                    end
                FN_REMOVE:
                    if (pos < 0) r.status = ST_NOTFOUND;
                    else contents.delete(pos);
                FN_FIND:
                    if (pos < 0) r.status = ST_NOTFOUND;
                default: ;
            endcase
            r.length = 7'(contents.size());
            r.empty = contents.size() == 0;
            pending.push_back(r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
            errors++;
        endtask

        task check_result(logic [47:0] tdata);
            list_result_t w;
            if (pending.size() == 0)
            begin
                report("unexpected transaction", tdata[31:0], 0);
                return;
            end
            w = pending.pop_front();
            if (tdata[1:0] != w.status) report("status", tdata[1:0], w.status);
            if (tdata[33:2] != w.data) report("data_out", tdata[33:2], w.data);
            if (tdata[40:34] != w.length) report("length", tdata[40:34], w.length);
            if (tdata[41] != w.empty) report("is_empty", tdata[41], w.empty);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;

    list_scoreboard board;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;
    logic [31:0] recent[$];

    doubly_linked_list_engine_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                board.note_request(s_axis_tdata[3:0], s_axis_tdata[35:4],
                                   s_axis_tdata[67:36]);
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            m_axis_tready <= $urandom_range(99) >= recv_idle_pct;
        end
    end

    always @(posedge clk)
    begin
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // The valid line stays high after an accepted transaction until the next
    // call or drain() updates it, so each time step assigns it at most once.
    task send_op(logic [3:0] fn, logic [31:0] k, logic [31:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'd0, v, k, fn};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (fn <= FN_INS_BEFORE)
        begin
            recent.push_back(v);
            if (recent.size() > 16) void'(recent.pop_front());
        end
    endtask

    function logic [31:0] pick_key();
        if (recent.size() > 0 && $urandom_range(3) != 0)
            return recent[$urandom_range(recent.size() - 1)];
        return $urandom_range(7);
    endfunction

    function logic [31:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom();
            default: return $urandom_range(7);
        endcase
    endfunction

    task drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    task random_phase(int count, int fill_bias);
        logic [3:0] fn;
        int roll;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(99);
            if (roll < fill_bias) fn = 4'($urandom_range(FN_INS_BEFORE));
            else if (roll < 97) fn = 4'($urandom_range(FN_FIND));
            else fn = 4'($urandom_range(15, 10));
            send_op(fn, pick_key(), pick_value());
        end
    endtask

    initial
    begin
        board = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        send_op(FN_POP_FRONT, 0, 0);
        send_op(FN_POP_BACK, 0, 0);
        send_op(FN_PEEK_FRONT, 0, 0);
        send_op(FN_PEEK_BACK, 0, 0);
        send_op(FN_FIND, 0, 0);
        send_op(FN_REMOVE, 0, 0);
        send_op(FN_INS_AFTER, 0, 1);
        send_op(FN_INS_BEFORE, 0, 1);
        send_op(FN_PUSH_FRONT, 0, 32'h8000_0000);
        send_op(FN_PUSH_BACK, 0, 32'h7FFF_FFFF);
        send_op(FN_INS_AFTER, 32'h8000_0000, 32'hFFFF_FFFF);
        send_op(FN_INS_BEFORE, 32'h7FFF_FFFF, 0);
        send_op(FN_PEEK_FRONT, 0, 0);
        send_op(FN_PEEK_BACK, 0, 0);
        send_op(FN_FIND, 32'hFFFF_FFFF, 0);
        send_op(FN_FIND, 5, 0);
        send_op(FN_REMOVE, 0, 0);
        send_op(4'd10, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(4'd15, 0, 0);
        send_op(FN_POP_BACK, 0, 0);
        send_op(FN_POP_FRONT, 0, 0);
        for (int i = 0; i < NODES; i++)
            send_op(FN_PUSH_BACK, 0, i);
        send_op(FN_PUSH_FRONT, 0, 99);
        send_op(FN_INS_AFTER, 3, 99);
        send_op(FN_INS_BEFORE, 1000, 99);
        drain();

        send_idle_pct = 28;
        recv_idle_pct = 55;
        random_phase(350, 30);
        send_idle_pct = 55;
        recv_idle_pct = 28;
        random_phase(350, 55);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(350, 45);

        drain();
        repeat (2 * NODES + 20) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

/* doubly_linked_list_engine_unit.f */
src/dll_pkg.sv
src/dll_datapath.sv
src/dll_ctrl.sv
src/doubly_linked_list_engine_unit.sv
src/dll_checker.sv
tb/sv/doubly_linked_list_engine_unit_test.sv
